// File: rtl/tarb_pkg.sv
`timescale 1ns / 1ps
package tarb_pkg;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_CONFIRM = 2'd1,
        OP_QUERY   = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_MISS   = 2'd1,
        ST_NOPEND = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    localparam int CFG_SERVER_MASK    = 0;
    localparam int CFG_START_SEQUENCE = 1;

    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 336;
    localparam int M_TDATA_W = 344;

    // one stored record, sequence number in the lowest bits
    typedef struct packed {
        logic signed [7:0] battery_percent;
        logic [31:0]       battery_volts;
        logic [31:0]       water;
        logic [31:0]       acidity;
        logic [31:0]       conductivity;
        logic [31:0]       humidity;
        logic [31:0]       ambient_temp;
        logic [63:0]       stamp_ms;
        logic [63:0]       seq;
    } rec_t;

endpackage

// File: rtl/tarb_ram.sv
`timescale 1ns / 1ps
module tarb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/telemetry_ack_ring_buffer.sv
`timescale 1ns / 1ps
// channel  | direction | tuser           | tdata (lowest bit up)
// s_       | in        | opcode          | confirm_seq, server_index, stamp_ms, ambient_temp,
//          |           |                 | humidity_word, conductivity_word, acidity_word,
//          |           |                 | water_word, battery_volts_word, battery_percent
// m_       | out       | status          | pending_count, total_count, out_seq, out_stamp_ms,
//          |           |                 | out_ambient_temp, out_humidity, out_conductivity,
//          |           |                 | out_acidity, out_water, out_battery_volts,
//          |           |                 | out_battery_percent
// cfg      | in        | -               | cfg_index selects server_mask (0) or start_sequence (1)
//
// one word at a time: add and query scan every held record (up to DEPTH), and a
// confirm first searches from the oldest record for a match and then scans; the
// record and ack memories are read one entry a cycle over their single read port;
// s_tready rises with the result, so the next word can be taken while it is shown
// reset clears pointers, the record count and the server mask; memories need no clearing pass
// s_tready is low while a word is in work; a stalled result waits in the output
// register while the next word is taken in
module telemetry_ack_ring_buffer #(
    parameter int DEPTH   = 64,
    parameter int SERVERS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [1:0]                      s_tuser,   // opcode
    input  logic [tarb_pkg::S_TDATA_W-1:0]  s_tdata,   // see table above
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [1:0]                      m_tuser,   // status
    output logic [tarb_pkg::M_TDATA_W-1:0]  m_tdata,   // see table above
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [63:0]                     cfg_wdata
);
    import tarb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [31:0] KEEP_MASK =
        (SERVERS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << SERVERS) - 32'd1);

    typedef enum logic [1:0] {IDLE, SRCH, SCAN, DONE} state_t;

    state_t            state_reg;
    logic [PTR_W-1:0]  wp_reg, oldest_reg, iss_slot_reg, rd_slot_reg;
    logic [CNT_W-1:0]  fill_reg, iss_cnt_reg, pend_reg;
    logic [63:0]       next_seq_reg, cseq_reg;
    logic [31:0]       mask_reg;
    logic [4:0]        idx_reg;
    opcode_t           op_reg;
    status_t           status_reg;
    logic              rd_vld_reg, found_reg;
    rec_t              rec_reg;
    logic              m_tvalid_reg;
    logic [1:0]        m_tuser_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    rec_t             in_rec, rec_rdata, out_rec;
    logic [31:0]      ack_rdata, ack_wdata, live, bit_mask;
    logic             s_fire, add_we, ack_we, issue, covered, match;
    logic [PTR_W-1:0] ack_waddr;
    opcode_t          in_op;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign in_op  = opcode_t'(s_tuser);
    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == IDLE);

    always_comb begin
        in_rec.seq             = next_seq_reg;
        in_rec.stamp_ms        = s_tdata[132:69];
        in_rec.ambient_temp    = s_tdata[164:133];
        in_rec.humidity        = s_tdata[196:165];
        in_rec.conductivity    = s_tdata[228:197];
        in_rec.acidity         = s_tdata[260:229];
        in_rec.water           = s_tdata[292:261];
        in_rec.battery_volts   = s_tdata[324:293];
        in_rec.battery_percent = s_tdata[332:325];
    end

    // sent test: zero mask counts as covered, bits beyond SERVERS ignored
    assign live     = mask_reg & KEEP_MASK;
    assign covered  = (live == 32'd0) || ((ack_rdata & live) == live);
    assign match    = (rec_rdata.seq == cseq_reg);
    assign issue    = (iss_cnt_reg != fill_reg);
    assign bit_mask = ({1'b0, idx_reg} < 6'(SERVERS)) ? (32'd1 << idx_reg) : 32'd0;

    assign add_we    = s_fire && (in_op == OP_ADD);
    assign ack_we    = add_we || ((state_reg == SRCH) && rd_vld_reg && match);
    assign ack_waddr = add_we ? wp_reg : rd_slot_reg;
    assign ack_wdata = add_we ? 32'd0 : (ack_rdata | bit_mask);

    tarb_ram #(.WIDTH($bits(rec_t)), .DEPTH(DEPTH)) u_rec_ram (
        .aclk  (aclk),
        .we    (add_we),
        .waddr (wp_reg),
        .wdata (in_rec),
        .raddr (iss_slot_reg),
        .rdata (rec_rdata)
    );

    tarb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ack_ram (
        .aclk  (aclk),
        .we    (ack_we),
        .waddr (ack_waddr),
        .wdata (ack_wdata),
        .raddr (iss_slot_reg),
        .rdata (ack_rdata)
    );

    // record fields are zero unless a query found a pending record
    assign out_rec = found_reg ? rec_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            wp_reg       <= '0;
            oldest_reg   <= '0;
            fill_reg     <= '0;
            next_seq_reg <= '0;
            mask_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in the last step the output register is refilled instead
            if (m_tvalid_reg && m_tready && state_reg != DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= in_op;
                        cseq_reg    <= s_tdata[63:0];
                        idx_reg     <= s_tdata[68:64];
                        iss_cnt_reg <= '0;
                        pend_reg    <= '0;
                        rd_vld_reg  <= 1'b0;
                        found_reg   <= 1'b0;
                        iss_slot_reg <= oldest_reg;
                        case (in_op)
                            OP_ADD: begin
                                status_reg   <= ST_DONE;
                                wp_reg       <= adv(wp_reg);
                                next_seq_reg <= next_seq_reg + 64'd1;
                                // full store: the oldest record is overwritten
                                if (fill_reg == CNT_W'(DEPTH)) begin
                                    oldest_reg   <= adv(oldest_reg);
                                    iss_slot_reg <= adv(oldest_reg);
                                end else begin
                                    fill_reg <= fill_reg + CNT_W'(1);
                                end
                                state_reg <= SCAN;
                            end
                            OP_CONFIRM: begin
                                status_reg <= ST_MISS;
                                state_reg  <= SRCH;
                            end
                            OP_QUERY: begin
                                status_reg <= ST_NOPEND;
                                state_reg  <= SCAN;
                            end
                            default: begin
                                status_reg <= ST_DONE;
                                state_reg  <= SCAN;
                            end
                        endcase
                    end
                end
                SRCH: begin
                    if ((rd_vld_reg && match) || (!issue && !rd_vld_reg)) begin
                        // first match gets its bit written this cycle
                        if (rd_vld_reg && match) begin
                            status_reg <= ST_DONE;
                        end
                        state_reg    <= SCAN;
                        iss_cnt_reg  <= '0;
                        iss_slot_reg <= oldest_reg;
                        rd_vld_reg   <= 1'b0;
                    end else begin
                        rd_vld_reg  <= issue;
                        rd_slot_reg <= iss_slot_reg;
                        if (issue) begin
                            iss_cnt_reg  <= iss_cnt_reg + CNT_W'(1);
                            iss_slot_reg <= adv(iss_slot_reg);
                        end
                    end
                end
                SCAN: begin
                    // pending count, and the oldest pending record for a query
                    if (rd_vld_reg && !covered) begin
                        pend_reg <= pend_reg + CNT_W'(1);
                        if (op_reg == OP_QUERY && !found_reg) begin
                            found_reg  <= 1'b1;
                            rec_reg    <= rec_rdata;
                            status_reg <= ST_DONE;
                        end
                    end
                    rd_vld_reg  <= issue;
                    rd_slot_reg <= iss_slot_reg;
                    if (issue) begin
                        iss_cnt_reg  <= iss_cnt_reg + CNT_W'(1);
                        iss_slot_reg <= adv(iss_slot_reg);
                    end
                    if (!issue && !rd_vld_reg) begin
                        state_reg <= DONE;
                    end
                end
                DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {2'b00, out_rec.battery_percent, out_rec.battery_volts,
                                         out_rec.water, out_rec.acidity, out_rec.conductivity,
                                         out_rec.humidity, out_rec.ambient_temp,
                                         out_rec.stamp_ms, out_rec.seq,
                                         COUNT_W'(fill_reg), COUNT_W'(pend_reg)};
                        state_reg    <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
            if (cfg_we) begin
                if (cfg_index == 1'(CFG_SERVER_MASK)) begin
                    mask_reg <= cfg_wdata[31:0];
                end else begin
                    next_seq_reg <= cfg_wdata;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

// File: rtl/tarb_checker.sv
`timescale 1ns / 1ps
module tarb_checker #(
    parameter int DEPTH = 64
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [1:0]                     m_tuser,
    input logic [tarb_pkg::M_TDATA_W-1:0] m_tdata
);
    import tarb_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready while a word is in work");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_pending_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && DEPTH < 128) |-> (m_tdata[6:0] <= m_tdata[13:7]))
        else $error("pending count above total");
endmodule

bind telemetry_ack_ring_buffer tarb_checker #(.DEPTH(DEPTH)) u_tarb_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tarb_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 150;    // outlasts the longest confirm scan

    // one predicted result word
    typedef struct {
        status_t    status;
        logic [6:0] pending;
        logic [6:0] total;
        rec_t       rec;
    } ring_result_t;

    // one row of the directed table: either a config write or an input word
    typedef struct {
        bit          is_cfg;
        int          cfg_sel;
        logic [63:0] cfg_value;
        opcode_t     op;
        logic [63:0] ack_seq;
        logic [4:0]  ack_server;
        rec_t        payload;
        bit          typed;      // expected status and counts written in below
        status_t     t_status;
        logic [6:0]  t_pending;
        logic [6:0]  t_total;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [1:0]           s_tuser;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [1:0]           m_tuser;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [63:0]          cfg_wdata;

    telemetry_ack_ring_buffer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the ring, its pointers and its registers
    rec_t        ring_rec [RING_DEPTH];
    logic [31:0] ring_ack [RING_DEPTH];
    int          ring_wp;
    int          ring_fill;
    logic [63:0] ring_next_seq;
    logic [31:0] ring_server_mask;

    ring_result_t pending_results[$];
    int           errors;
    int           cycles;
    int           send_idle_pct;
    int           recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("telemetry_ack_ring_buffer: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("error @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int ring_slot(input int age);
        return (ring_wp + RING_DEPTH - ring_fill + age) % RING_DEPTH;
    endfunction

    // a zero mask means every record counts as sent
    function automatic bit ring_sent(input int slot);
        if (ring_server_mask == 32'd0)
            return 1'b1;
        return (ring_ack[slot] & ring_server_mask) == ring_server_mask;
    endfunction

    // advances the shadow ring by one input word and returns the result it causes
    function automatic ring_result_t ring_apply(input opcode_t op, input logic [63:0] ack_seq,
                                                input logic [4:0] ack_server, input rec_t payload);
        ring_result_t r;
        int           s;
        int           n;
        r.status = ST_DONE;
        r.rec    = '0;
        case (op)
            OP_ADD: begin
                ring_rec[ring_wp]     = payload;
                ring_rec[ring_wp].seq = ring_next_seq;
                ring_ack[ring_wp]     = 32'd0;
                ring_next_seq         = ring_next_seq + 64'd1;
                ring_wp               = (ring_wp + 1) % RING_DEPTH;
                if (ring_fill < RING_DEPTH)
                    ring_fill++;
            end
            OP_CONFIRM: begin
                // oldest matching record wins on duplicate sequence numbers
                r.status = ST_MISS;
                for (int i = 0; i < ring_fill; i++) begin
                    s = ring_slot(i);
                    if (ring_rec[s].seq == ack_seq) begin
                        ring_ack[s] = ring_ack[s] | (32'd1 << ack_server);
                        r.status    = ST_DONE;
                        break;
                    end
                end
            end
            OP_QUERY: begin
                r.status = ST_NOPEND;
                for (int i = 0; i < ring_fill; i++) begin
                    s = ring_slot(i);
                    if (!ring_sent(s)) begin
                        r.status = ST_DONE;
                        r.rec    = ring_rec[s];
                        break;
                    end
                end
            end
            default: ;
        endcase
        n = 0;
        for (int i = 0; i < ring_fill; i++)
            if (!ring_sent(ring_slot(i)))
                n++;
        r.pending = n[6:0];
        r.total   = ring_fill[6:0];
        return r;
    endfunction

    function automatic rec_t random_payload();
        rec_t p;
        p.seq             = '0;
        p.stamp_ms        = {$urandom, $urandom};
        p.ambient_temp    = $urandom;
        p.humidity        = $urandom;
        p.conductivity    = $urandom;
        p.acidity         = $urandom;
        p.water           = $urandom;
        p.battery_volts   = $urandom;
        p.battery_percent = 8'($urandom_range(255));
        return p;
    endfunction

    // register writes only once the block has drained
    task automatic write_register(input int sel, input logic [63:0] value);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= (sel == CFG_START_SEQUENCE);
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (sel == CFG_SERVER_MASK) begin
            ring_server_mask = value[31:0];
        end else begin
            ring_next_seq = value;
        end
    endtask

    // drives one word; valid is only lowered ahead of a gap
    task automatic send_word(input opcode_t op, input logic [63:0] ack_seq,
                             input logic [4:0] ack_server, input rec_t payload,
                             input bit typed, input status_t t_status,
                             input logic [6:0] t_pending, input logic [6:0] t_total);
        ring_result_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, payload.battery_percent, payload.battery_volts, payload.water,
                     payload.acidity, payload.conductivity, payload.humidity,
                     payload.ambient_temp, payload.stamp_ms, ack_server, ack_seq};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = ring_apply(op, ack_seq, ack_server, payload);
        if (typed && (r.status != t_status || r.pending != t_pending || r.total != t_total))
            report_mismatch($sformatf("directed %s: table says status %0d pend %0d total %0d",
                            op.name(), t_status, t_pending, t_total));
        pending_results.push_back(r);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare one field of the result word
    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // result monitor
    always @(posedge aclk) begin
        ring_result_t exp_r;
        rec_t         got_rec;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                exp_r   = pending_results.pop_front();
                got_rec = m_tdata[341:14];
                check_field("status", 64'(m_tuser), 64'(exp_r.status));
                check_field("pending_count", 64'(m_tdata[6:0]), 64'(exp_r.pending));
                check_field("total_count", 64'(m_tdata[13:7]), 64'(exp_r.total));
                check_field("out_seq", got_rec.seq, exp_r.rec.seq);
                check_field("out_stamp_ms", got_rec.stamp_ms, exp_r.rec.stamp_ms);
                check_field("out_ambient_temp", 64'(got_rec.ambient_temp),
                            64'(exp_r.rec.ambient_temp));
                check_field("out_humidity", 64'(got_rec.humidity), 64'(exp_r.rec.humidity));
                check_field("out_conductivity", 64'(got_rec.conductivity),
                            64'(exp_r.rec.conductivity));
                check_field("out_acidity", 64'(got_rec.acidity), 64'(exp_r.rec.acidity));
                check_field("out_water", 64'(got_rec.water), 64'(exp_r.rec.water));
                check_field("out_battery_volts", 64'(got_rec.battery_volts),
                            64'(exp_r.rec.battery_volts));
                check_field("out_battery_percent", 64'(got_rec.battery_percent),
                            64'(exp_r.rec.battery_percent));
                check_field("tdata pad", 64'(m_tdata[343:342]), 64'd0);
            end
        end
    end

    dir_row_t dir_rows[$];

    task automatic add_row(input opcode_t op, input logic [63:0] ack_seq,
                           input logic [4:0] ack_server, input rec_t payload);
        dir_row_t d;
        d.is_cfg     = 1'b0;
        d.cfg_sel    = 0;
        d.cfg_value  = '0;
        d.op         = op;
        d.ack_seq    = ack_seq;
        d.ack_server = ack_server;
        d.payload    = payload;
        d.typed      = 1'b0;
        d.t_status   = ST_DONE;
        d.t_pending  = '0;
        d.t_total    = '0;
        dir_rows.push_back(d);
    endtask

    task automatic add_typed(input opcode_t op, input logic [63:0] ack_seq, input rec_t payload,
                             input status_t st, input logic [6:0] pend, input logic [6:0] tot);
        add_row(op, ack_seq, 5'd0, payload);
        dir_rows[$].typed     = 1'b1;
        dir_rows[$].t_status  = st;
        dir_rows[$].t_pending = pend;
        dir_rows[$].t_total   = tot;
    endtask

    task automatic add_cfg(input int sel, input logic [63:0] value);
        dir_row_t d;
        d.is_cfg     = 1'b1;
        d.cfg_sel    = sel;
        d.cfg_value  = value;
        d.op         = OP_NONE;
        d.ack_seq    = '0;
        d.ack_server = '0;
        d.payload    = '0;
        d.typed      = 1'b0;
        d.t_status   = ST_DONE;
        d.t_pending  = '0;
        d.t_total    = '0;
        dir_rows.push_back(d);
    endtask

    // mask with up to n random bits set
    function automatic logic [31:0] few_bits(input int n);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < n; i++)
            m[$urandom_range(31)] = 1'b1;
        return m;
    endfunction

    initial begin
        rec_t        ones_rec;
        rec_t        zero_rec;
        rec_t        p;
        opcode_t     op;
        logic [63:0] ack_seq;
        logic [4:0]  ack_server;
        logic [31:0] phase_mask [8];
        logic [63:0] phase_start[8];
        int          pick;
        int          bitpos;

        errors         = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = '0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = 1'b0;
        cfg_wdata      = '0;

        ring_wp          = 0;
        ring_fill        = 0;
        ring_next_seq    = '0;
        ring_server_mask = '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_rec[i] = '0;
            ring_ack[i] = '0;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        ones_rec                 = '1;
        zero_rec                 = '0;
        zero_rec.battery_percent = -8'sd128;

        // directed part: empty ring, unused opcode, extremes, sequence wrap, duplicates
        add_typed(OP_QUERY, 64'd0, zero_rec, ST_NOPEND, 7'd0, 7'd0);
        add_typed(OP_CONFIRM, 64'd0, zero_rec, ST_MISS, 7'd0, 7'd0);
        add_typed(OP_NONE, 64'd0, ones_rec, ST_DONE, 7'd0, 7'd0);
        add_typed(OP_ADD, 64'd0, ones_rec, ST_DONE, 7'd0, 7'd1);
        add_typed(OP_ADD, 64'd0, zero_rec, ST_DONE, 7'd0, 7'd2);
        add_typed(OP_QUERY, 64'd0, zero_rec, ST_NOPEND, 7'd0, 7'd2);   // zero mask: all sent
        add_cfg(CFG_SERVER_MASK, 64'hFFFF_FFFF);
        add_row(OP_QUERY, 64'd0, 5'd0, zero_rec);
        add_row(OP_CONFIRM, 64'd0, 5'd31, zero_rec);
        add_row(OP_CONFIRM, 64'd1, 5'd0, zero_rec);
        add_cfg(CFG_START_SEQUENCE, 64'hFFFF_FFFF_FFFF_FFFE);
        add_row(OP_ADD, 64'd0, 5'd0, ones_rec);
        add_row(OP_ADD, 64'd0, 5'd0, zero_rec);
        add_row(OP_ADD, 64'd0, 5'd0, ones_rec);                        // sequence wraps to 0
        add_row(OP_CONFIRM, 64'd0, 5'd5, zero_rec);                    // duplicate: oldest
        add_row(OP_QUERY, 64'd0, 5'd0, zero_rec);
        add_row(OP_CONFIRM, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, zero_rec);
        add_cfg(CFG_SERVER_MASK, 64'h1);
        add_row(OP_QUERY, 64'd0, 5'd0, zero_rec);
        add_row(OP_CONFIRM, 64'd1, 5'd0, zero_rec);
        add_row(OP_CONFIRM, 64'd0, 5'd0, zero_rec);
        add_row(OP_QUERY, 64'd0, 5'd0, zero_rec);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                stop_sending();
                write_register(dir_rows[i].cfg_sel, dir_rows[i].cfg_value);
            end else begin
                send_word(dir_rows[i].op, dir_rows[i].ack_seq, dir_rows[i].ack_server,
                          dir_rows[i].payload, dir_rows[i].typed, dir_rows[i].t_status,
                          dir_rows[i].t_pending, dir_rows[i].t_total);
            end
        end

        // random part: eight phases, four idle modes each under two settings
        phase_mask  = '{few_bits(3), 32'hFFFF_FFFF, 32'd0, 32'h8000_0001,
                        $urandom, few_bits(1), $urandom, few_bits(2)};
        phase_start = '{{$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFF0, 64'd0,
                        {$urandom, $urandom}, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                        {$urandom, $urandom}, 64'h8000_0000_0000_0000};
        for (int ph = 0; ph < 8; ph++) begin
            stop_sending();
            write_register(CFG_SERVER_MASK, {32'd0, phase_mask[ph]});
            write_register(CFG_START_SEQUENCE, phase_start[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int k = 0; k < 155; k++) begin
                pick       = $urandom_range(99);
                p          = random_payload();
                ack_seq    = {$urandom, $urandom};
                ack_server = 5'($urandom_range(31));
                if (pick < 42) begin
                    op = OP_ADD;
                end else if (pick < 77) begin
                    op = OP_CONFIRM;
                    // mostly a held sequence number and a server the mask needs
                    if (ring_fill != 0 && $urandom_range(99) < 80)
                        ack_seq = ring_rec[ring_slot($urandom_range(ring_fill - 1))].seq;
                    if (ring_server_mask != 0 && $urandom_range(99) < 75) begin
                        do bitpos = $urandom_range(31);
                        while (!ring_server_mask[bitpos]);
                        ack_server = bitpos[4:0];
                    end
                end else if (pick < 96) begin
                    op = OP_QUERY;
                end else begin
                    op = OP_NONE;
                end
                send_word(op, ack_seq, ack_server, p, 1'b0, ST_DONE, 7'd0, 7'd0);
            end
        end
        stop_sending();

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (errors == 0) begin
            $display("telemetry_ack_ring_buffer: match");
        end else begin
            $display("telemetry_ack_ring_buffer: mismatch");
        end
        $finish;
    end

endmodule
